/* rtl/mau_pkg.sv */
`timescale 1ns / 1ps
// Shared types, codes and widths for the matrix arithmetic unit.
// No dependencies; every other file in rtl/ uses this package.
package mau_pkg;

   localparam int ELEM_W = 32;   // Q16.16 element
   localparam int IDX_W  = 3;    // row or column index
   localparam int ADDR_W = 2 * IDX_W;
   localparam int DIM_W  = 4;    // configured dimension
   localparam int PROD_W = 2 * ELEM_W;
   localparam int RND_W  = PROD_W - 16;
   // eight rounded terms of at most 2^46 each fit with margin
   localparam int ACC_W  = 52;

   localparam logic [DIM_W-1:0] MAX_DIM = 4'd8;

   localparam logic signed [ELEM_W-1:0] SCALE_RESET = 32'sd65536;

   // input item kinds
   localparam logic [1:0] KIND_LOAD_A = 2'd0;
   localparam logic [1:0] KIND_LOAD_B = 2'd1;
   localparam logic [1:0] KIND_START  = 2'd2;

   // operations
   localparam logic [1:0] OP_ADD   = 2'd0;
   localparam logic [1:0] OP_SUB   = 2'd1;
   localparam logic [1:0] OP_MUL   = 2'd2;
   localparam logic [1:0] OP_SCALE = 2'd3;

   // result status
   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_DIM   = 2'd1;
   localparam logic [1:0] STAT_EMPTY = 2'd2;
   localparam logic [1:0] STAT_SAT   = 2'd3;

   // register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] REG_OP_MODE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_A_ROWS  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_A_COLS  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_B_ROWS  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_B_COLS  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_SCALE   = 3'd5;

   // one term travelling down the arithmetic pipeline
   typedef struct packed {
      logic       vld;
      logic       first;
      logic       last;
      logic [1:0] op;
   } term_ctrl_type;

   // finished element held by the arithmetic unit
   typedef struct packed {
      logic              vld;
      logic              sat;
      logic [ELEM_W-1:0] value;
   } elem_res_type;

endpackage

/* rtl/mau_channels.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the matrix arithmetic unit:
// request, response and register write. Depends on mau_pkg.
interface mau_req_if;
   logic                            valid;
   logic                            ready;
   logic [1:0]                      kind;
   logic signed [mau_pkg::ELEM_W-1:0] elem_value;
   logic [mau_pkg::IDX_W-1:0]       elem_row;
   logic [mau_pkg::IDX_W-1:0]       elem_col;

   modport source (output valid, kind, elem_value, elem_row, elem_col, input ready);
   modport sink   (input valid, kind, elem_value, elem_row, elem_col, output ready);
endinterface

interface mau_rsp_if;
   logic                            valid;
   logic                            ready;
   logic signed [mau_pkg::ELEM_W-1:0] out_value;
   logic [mau_pkg::IDX_W-1:0]       out_row;
   logic [mau_pkg::IDX_W-1:0]       out_col;
   logic                            out_last;
   logic [1:0]                      out_status;

   modport source (output valid, out_value, out_row, out_col, out_last, out_status,
                   input ready);
   modport sink   (input valid, out_value, out_row, out_col, out_last, out_status,
                   output ready);
endinterface

interface mau_csr_if;
   logic                             valid;
   logic                             ready;
   logic [mau_pkg::CSR_IDX_W-1:0]    index;
   logic [mau_pkg::ELEM_W-1:0]       data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/matrix_arithmetic_unit.sv */
`timescale 1ns / 1ps
// Matrix arithmetic unit: A+B, A-B, A*B or scale*A on matrices up to 8x8 in
// signed Q16.16, results saturated to 32 bits. Uses mau_pkg, mau_channels, mau_alu.
//
// Channels: req_bus carries load items (kind 0 to A, kind 1 to B, at elem_row,
// elem_col) and start items (kind 2). rsp_bus returns one transfer per result
// element, row by row, out_last on the final one; a bad shape or an empty
// result gives a single transfer with status set. csr_bus writes the
// registers and is always ready; write it only while the block is idle.
// Loads are taken back to back while the block is idle. A start passes
// the check state, then issues the terms of each result element, where
// terms is a_cols for the product and 1 otherwise: the shared multiplier
// and accumulator handle one term a cycle, and each element drains the
// store read, multiply, round and accumulate stages before the next one
// starts. req_bus is not ready from the start transfer until the last
// element has been registered for output.
// Reset clears the registers (scale to 1.0) and the sequencer; the stores
// hold no defined value until written and need no clearing pass.
// A stalled rsp_bus holds the result register and the sequencer waits.
module matrix_arithmetic_unit (
   input  logic            clock,
   input  logic            reset,
   mau_req_if.sink         req_bus,
   mau_rsp_if.source       rsp_bus,
   mau_csr_if.sink         csr_bus
);
   import mau_pkg::*;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_CHECK = 2'd1;
   localparam logic [1:0] S_ISSUE = 2'd2;
   localparam logic [1:0] S_WAIT  = 2'd3;

   // registers
   logic [1:0]               op_mode_ff;
   logic [DIM_W-1:0]         a_rows_ff, a_cols_ff, b_rows_ff, b_cols_ff;
   logic signed [ELEM_W-1:0] scale_ff;

   logic [1:0]               state_ff, state_in;
   logic [IDX_W-1:0]         row_ff, row_in, col_ff, col_in, k_ff, k_in;
   term_ctrl_type            issue_ff, issue_in;

   logic [ELEM_W-1:0]        store_a [2**ADDR_W];
   logic [ELEM_W-1:0]        store_b [2**ADDR_W];
   logic [ELEM_W-1:0]        rd_a_ff, rd_b_ff;
   logic [ADDR_W-1:0]        wr_addr, rd_addr_a, rd_addr_b;
   logic                     load_a, load_b, req_xfer;

   logic                     out_vld_ff, out_vld_in;
   logic [ELEM_W-1:0]        out_value_ff;
   logic [IDX_W-1:0]         out_row_ff, out_col_ff;
   logic                     out_last_ff;
   logic [1:0]               out_status_ff;
   logic                     out_load, slot_free;
   logic [ELEM_W-1:0]        load_value;
   logic                     load_last;
   logic [1:0]               load_status;

   logic [DIM_W-1:0]         ar_e, ac_e, br_e, bc_e, rr_e, rc_e, term_cnt;
   logic                     oversize, mismatch, empty, chk_error;
   logic                     row_last, col_last, elem_last, term_last;

   elem_res_type             alu_res;
   logic                     take;

   // ---------------- register port ----------------
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         op_mode_ff <= OP_ADD;
         a_rows_ff  <= '0;
         a_cols_ff  <= '0;
         b_rows_ff  <= '0;
         b_cols_ff  <= '0;
         scale_ff   <= SCALE_RESET;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            REG_OP_MODE: op_mode_ff <= csr_bus.data[1:0];
            REG_A_ROWS:  a_rows_ff  <= csr_bus.data[DIM_W-1:0];
            REG_A_COLS:  a_cols_ff  <= csr_bus.data[DIM_W-1:0];
            REG_B_ROWS:  b_rows_ff  <= csr_bus.data[DIM_W-1:0];
            REG_B_COLS:  b_cols_ff  <= csr_bus.data[DIM_W-1:0];
            REG_SCALE:   scale_ff   <= $signed(csr_bus.data);
            default: ;
         endcase
      end
   end

   // ---------------- shape checks ----------------
   always_comb begin
      // a matrix with no rows or no columns counts as 0 x 0
      if (a_rows_ff == '0 || a_cols_ff == '0) begin
         ar_e = '0;
         ac_e = '0;
      end else begin
         ar_e = a_rows_ff;
         ac_e = a_cols_ff;
      end
      if (b_rows_ff == '0 || b_cols_ff == '0) begin
         br_e = '0;
         bc_e = '0;
      end else begin
         br_e = b_rows_ff;
         bc_e = b_cols_ff;
      end
      oversize = (ar_e > MAX_DIM) || (ac_e > MAX_DIM) ||
                 ((op_mode_ff != OP_SCALE) && ((br_e > MAX_DIM) || (bc_e > MAX_DIM)));
      case (op_mode_ff)
         OP_MUL:   mismatch = (ac_e != br_e);
         OP_SCALE: mismatch = 1'b0;
         default:  mismatch = (ar_e != br_e) || (ac_e != bc_e);
      endcase
      rr_e      = ar_e;
      rc_e      = (op_mode_ff == OP_MUL) ? bc_e : ac_e;
      term_cnt  = (op_mode_ff == OP_MUL) ? ac_e : 4'd1;
      empty     = (rr_e == '0) || (rc_e == '0);
      chk_error = oversize || mismatch || empty;
      row_last  = ({1'b0, row_ff} == rr_e - 4'd1);
      col_last  = ({1'b0, col_ff} == rc_e - 4'd1);
      elem_last = row_last && col_last;
      term_last = ({1'b0, k_ff} == term_cnt - 4'd1);
   end

   // ---------------- stores ----------------
   assign req_bus.ready = (state_ff == S_IDLE);
   assign req_xfer      = req_bus.valid && req_bus.ready;
   assign load_a        = req_xfer && (req_bus.kind == KIND_LOAD_A);
   assign load_b        = req_xfer && (req_bus.kind == KIND_LOAD_B);
   assign wr_addr       = {req_bus.elem_row, req_bus.elem_col};

   always_comb begin
      if (op_mode_ff == OP_MUL) begin
         rd_addr_a = {row_ff, k_ff};
         rd_addr_b = {k_ff, col_ff};
      end else begin
         rd_addr_a = {row_ff, col_ff};
         rd_addr_b = {row_ff, col_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (load_a) begin
         store_a[wr_addr] <= req_bus.elem_value;
      end
      if (load_b) begin
         store_b[wr_addr] <= req_bus.elem_value;
      end
      rd_a_ff <= store_a[rd_addr_a];
      rd_b_ff <= store_b[rd_addr_b];
   end

   // ---------------- sequencer ----------------
   assign slot_free = !out_vld_ff || rsp_bus.ready;

   always_comb begin
      state_in    = state_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      k_in        = k_ff;
      issue_in    = '0;
      out_load    = 1'b0;
      load_value  = '0;
      load_last   = 1'b0;
      load_status = STAT_OK;
      take        = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer && req_bus.kind == KIND_START) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (chk_error) begin
               if (slot_free) begin
                  out_load    = 1'b1;
                  load_last   = 1'b1;
                  load_status = empty && !oversize && !mismatch ? STAT_EMPTY : STAT_DIM;
                  state_in    = S_IDLE;
               end
            end else begin
               row_in   = '0;
               col_in   = '0;
               k_in     = '0;
               state_in = S_ISSUE;
            end
         end
         S_ISSUE: begin
            issue_in.vld   = 1'b1;
            issue_in.first = (k_ff == '0);
            issue_in.last  = term_last;
            issue_in.op    = op_mode_ff;
            if (term_last) begin
               k_in     = '0;
               state_in = S_WAIT;
            end else begin
               k_in = k_ff + 3'd1;
            end
         end
         S_WAIT: begin
            if (alu_res.vld && slot_free) begin
               out_load    = 1'b1;
               take        = 1'b1;
               load_value  = alu_res.value;
               load_last   = elem_last;
               load_status = alu_res.sat ? STAT_SAT : STAT_OK;
               if (elem_last) begin
                  state_in = S_IDLE;
               end else begin
                  if (col_last) begin
                     col_in = '0;
                     row_in = row_ff + 3'd1;
                  end else begin
                     col_in = col_ff + 3'd1;
                  end
                  state_in = S_ISSUE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         row_ff   <= '0;
         col_ff   <= '0;
         k_ff     <= '0;
         issue_ff <= '0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         k_ff     <= k_in;
         issue_ff <= issue_in;
      end
   end

   mau_alu u_alu (
      .clock (clock),
      .reset (reset),
      .term  (issue_ff),
      .opa   ($signed(rd_a_ff)),
      .opb   ($signed(rd_b_ff)),
      .scale (scale_ff),
      .take  (take),
      .res   (alu_res)
   );

   // ---------------- result register ----------------
   assign out_vld_in = out_load ? 1'b1 : (rsp_bus.ready ? 1'b0 : out_vld_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
      end
   end

   // error and empty transfers carry index 0
   always_ff @(posedge clock) begin
      if (out_load) begin
         out_value_ff  <= load_value;
         out_row_ff    <= (state_ff == S_WAIT) ? row_ff : '0;
         out_col_ff    <= (state_ff == S_WAIT) ? col_ff : '0;
         out_last_ff   <= load_last;
         out_status_ff <= load_status;
      end
   end

   assign rsp_bus.valid      = out_vld_ff;
   assign rsp_bus.out_value  = $signed(out_value_ff);
   assign rsp_bus.out_row    = out_row_ff;
   assign rsp_bus.out_col    = out_col_ff;
   assign rsp_bus.out_last   = out_last_ff;
   assign rsp_bus.out_status = out_status_ff;

   // ---------------- assertions ----------------
   a_res_only_in_wait: assert property (@(posedge clock) disable iff (reset)
      alu_res.vld |-> (state_ff == S_WAIT))
      else $error("element result outside the wait state");

   a_term_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ISSUE) |-> ({1'b0, k_ff} < term_cnt))
      else $error("term index beyond the term count");

   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      (out_load && load_last) |=> (state_ff == S_IDLE) && !alu_res.vld)
      else $error("run not finished after its last transfer");

   a_issue_from_seq: assert property (@(posedge clock) disable iff (reset)
      issue_ff.vld |-> ($past(state_ff) == S_ISSUE))
      else $error("term issued outside the issue state");

endmodule

/* rtl/mau_alu.sv */
`timescale 1ns / 1ps
// Shared arithmetic pipeline: add/subtract or 32x32 multiply, Q16.16 rounding,
// accumulation and saturation of one result element. Depends on mau_pkg.
module mau_alu (
   input  logic                          clock,
   input  logic                          reset,
   input  mau_pkg::term_ctrl_type        term,
   input  logic signed [mau_pkg::ELEM_W-1:0] opa,
   input  logic signed [mau_pkg::ELEM_W-1:0] opb,
   input  logic signed [mau_pkg::ELEM_W-1:0] scale,
   input  logic                          take,
   output mau_pkg::elem_res_type         res
);
   import mau_pkg::*;

   term_ctrl_type             p1_ff, p2_ff;
   logic signed [PROD_W-1:0]  mul_ff, mul_in;
   logic signed [ELEM_W:0]    sum_ff, sum_in;
   logic signed [RND_W-1:0]   rnd_ff, rnd_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic                      res_vld_ff, res_vld_in;
   logic signed [ELEM_W-1:0]  mul_x;
   logic signed [PROD_W-1:0]  rnd_full;
   logic                      over, under;

   // stage 1: one multiplier, one adder
   always_comb begin
      mul_x  = (term.op == OP_SCALE) ? scale : opb;
      mul_in = 64'(opa) * 64'(mul_x);
      if (term.op == OP_SUB) begin
         sum_in = 33'(opa) - 33'(opb);
      end else begin
         sum_in = 33'(opa) + 33'(opb);
      end
   end

   // stage 2: round products half up to Q16.16, pass sums through
   always_comb begin
      rnd_full = mul_ff + 64'sd32768;
      if (p1_ff.op == OP_MUL || p1_ff.op == OP_SCALE) begin
         rnd_in = $signed(rnd_full[PROD_W-1:16]);
      end else begin
         rnd_in = 48'(sum_ff);
      end
   end

   // stage 3: accumulate, restart on the first term of an element
   always_comb begin
      acc_in     = acc_ff;
      res_vld_in = res_vld_ff;
      if (take) begin
         res_vld_in = 1'b0;
      end
      if (p2_ff.vld) begin
         acc_in = (p2_ff.first ? 52'sd0 : acc_ff) + 52'(rnd_ff);
         if (p2_ff.last) begin
            res_vld_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_ff      <= '0;
         p2_ff      <= '0;
         acc_ff     <= '0;
         res_vld_ff <= 1'b0;
      end else begin
         p1_ff      <= term;
         p2_ff      <= p1_ff;
         acc_ff     <= acc_in;
         res_vld_ff <= res_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      mul_ff <= mul_in;
      sum_ff <= sum_in;
      rnd_ff <= rnd_in;
   end

   // clamp when the bits above the sign of a 32-bit value disagree
   always_comb begin
      over      = !acc_ff[ACC_W-1] && (acc_ff[ACC_W-2:ELEM_W-1] != '0);
      under     = acc_ff[ACC_W-1] && (acc_ff[ACC_W-2:ELEM_W-1] != '1);
      res.vld   = res_vld_ff;
      res.sat   = over || under;
      if (over) begin
         res.value = 32'h7fff_ffff;
      end else if (under) begin
         res.value = 32'h8000_0000;
      end else begin
         res.value = acc_ff[ELEM_W-1:0];
      end
   end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for matrix_arithmetic_unit: loads A and B, runs all four
// operations under changing shapes and compares every result transfer with a local
// Q16.16 predictor. Depends on mau_pkg, mau_channels and the RTL top level.
module tb_top;
   import mau_pkg::*;

   localparam logic [1:0] KIND_UNUSED = 2'd3;   // ignored by the block
   localparam int ITEM_TARGET  = 280;
   localparam int DRAIN_CYCLES = 16;             // margin over the check state and one 8-term element

   typedef struct {
      logic signed [ELEM_W-1:0] value;
      logic [IDX_W-1:0]         row;
      logic [IDX_W-1:0]         col;
      logic                     last;
      logic [1:0]               status;
   } elem_result_type;

   typedef enum {RX_STREAM, RX_RANDOM, RX_BURSTY} rx_mode_type;

   logic clock = 1'b0;
   logic reset;

   mau_req_if req_bus ();
   mau_rsp_if rsp_bus ();
   mau_csr_if csr_bus ();

   matrix_arithmetic_unit u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always #5 clock = ~clock;

   // predictor state: register copies and the two element stores
   logic [1:0]               cfg_op     = OP_ADD;
   logic [DIM_W-1:0]         cfg_a_rows = '0;
   logic [DIM_W-1:0]         cfg_a_cols = '0;
   logic [DIM_W-1:0]         cfg_b_rows = '0;
   logic [DIM_W-1:0]         cfg_b_cols = '0;
   logic signed [ELEM_W-1:0] cfg_scale  = SCALE_RESET;
   logic signed [ELEM_W-1:0] mat_a [64];
   logic signed [ELEM_W-1:0] mat_b [64];
   bit [63:0]                mat_a_loaded = '0;
   bit [63:0]                mat_b_loaded = '0;

   elem_result_type pending_elems[$];

   int error_count    = 0;
   int items_sent     = 0;
   int starts_sent    = 0;
   int elems_checked  = 0;
   int sat_seen       = 0;
   int flagged_seen   = 0;
   int burst_left     = 0;

   // ---------------------------------------------------------------- predictor

   // effective result shape; zero-size matrices collapse to 0 x 0 first
   function automatic logic [1:0] run_shape(output int rows, output int cols);
      int ar, ac, br, bc;
      ar = int'(cfg_a_rows);
      ac = int'(cfg_a_cols);
      br = int'(cfg_b_rows);
      bc = int'(cfg_b_cols);
      rows = 0;
      cols = 0;
      if (ar == 0 || ac == 0) begin
         ar = 0;
         ac = 0;
      end
      if (br == 0 || bc == 0) begin
         br = 0;
         bc = 0;
      end
      if (ar > MAX_DIM || ac > MAX_DIM ||
          (cfg_op != OP_SCALE && (br > MAX_DIM || bc > MAX_DIM)))
         return STAT_DIM;
      case (cfg_op)
         OP_MUL: begin
            if (ac != br)
               return STAT_DIM;
            rows = ar;
            cols = bc;
            if (rows == 0 || cols == 0) begin
               rows = 0;
               cols = 0;
            end
         end
         OP_SCALE: begin
            rows = ar;
            cols = ac;
         end
         default: begin
            if (ar != br || ac != bc)
               return STAT_DIM;
            rows = ar;
            cols = ac;
         end
      endcase
      return (rows == 0) ? STAT_EMPTY : STAT_OK;
   endfunction

   function automatic longint round_q16(longint prod);
      return (prod + 64'sd32768) >>> 16;
   endfunction

   function automatic void predict_elements();
      logic [1:0]      shape;
      int              rows, cols, ix, inner;
      longint          acc;
      elem_result_type res;
      shape = run_shape(rows, cols);
      if (shape != STAT_OK) begin
         res = '{value: '0, row: '0, col: '0, last: 1'b1, status: shape};
         pending_elems = {pending_elems, res};
         return;
      end
      for (int r = 0; r < rows; r++) begin
         for (int c = 0; c < cols; c++) begin
            ix = r * 8 + c;
            case (cfg_op)
               OP_ADD:   acc = longint'(mat_a[ix]) + longint'(mat_b[ix]);
               OP_SUB:   acc = longint'(mat_a[ix]) - longint'(mat_b[ix]);
               OP_SCALE: acc = round_q16(longint'(cfg_scale) * longint'(mat_a[ix]));
               default: begin
                  acc = 0;
                  inner = int'(cfg_a_cols);
                  for (int i = 0; i < inner; i++)
                     acc += round_q16(longint'(mat_a[r * 8 + i]) *
                                      longint'(mat_b[i * 8 + c]));
               end
            endcase
            res.status = STAT_OK;
            if (acc > 64'sd2147483647) begin
               acc = 64'sd2147483647;
               res.status = STAT_SAT;
            end else if (acc < -64'sd2147483648) begin
               acc = -64'sd2147483648;
               res.status = STAT_SAT;
            end
            res.value = acc[ELEM_W-1:0];
            res.row   = r[IDX_W-1:0];
            res.col   = c[IDX_W-1:0];
            res.last  = (r == rows - 1 && c == cols - 1);
            pending_elems = {pending_elems, res};
         end
      end
   endfunction

   function automatic void absorb_item(logic [1:0] kind, logic signed [ELEM_W-1:0] value,
                                       logic [IDX_W-1:0] row, logic [IDX_W-1:0] col);
      logic [ADDR_W-1:0] idx;
      idx = {row, col};
      case (kind)
         KIND_LOAD_A: begin
            mat_a[idx] = value;
            mat_a_loaded[idx] = 1'b1;
         end
         KIND_LOAD_B: begin
            mat_b[idx] = value;
            mat_b_loaded[idx] = 1'b1;
         end
         KIND_START: predict_elements();
         default: ;
      endcase
   endfunction

   // ---------------------------------------------------------------- drivers

   function automatic logic signed [ELEM_W-1:0] rand_elem();
      case ($urandom_range(0, 9))
         0: return 32'sh7FFF_FFFF;
         1: return 32'sh8000_0000;
         2: return 32'sd0;
         3: return -32'sd1;
         4, 5, 6, 7: return int'($urandom_range(0, 1 << 20)) - (1 << 19);  // +/-8.0
         default: return $urandom();
      endcase
   endfunction

   // random junk above the field so that unused data bits toggle too
   function automatic logic [31:0] pad_field(logic [31:0] field, int width);
      return ($urandom() << width) | field;
   endfunction

   task automatic send_item(logic [1:0] kind, logic signed [ELEM_W-1:0] value,
                            logic [IDX_W-1:0] row, logic [IDX_W-1:0] col);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         if ($urandom_range(0, 3) != 0) begin
            gap = $urandom_range(1, 6);
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_bus.valid      <= 1'b1;
      req_bus.kind       <= kind;
      req_bus.elem_value <= value;
      req_bus.elem_row   <= row;
      req_bus.elem_col   <= col;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      absorb_item(kind, value, row, col);
      burst_left--;
      if (kind != KIND_UNUSED)
         items_sent++;
      if (kind == KIND_START)
         starts_sent++;
   endtask

   task automatic send_start();
      send_item(KIND_START, $urandom(), IDX_W'($urandom()), IDX_W'($urandom()));
   endtask

   task automatic wait_until_drained();
      req_bus.valid <= 1'b0;
      while (pending_elems.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] index, logic [31:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data  <= data;
      @(posedge clock);
      while (csr_bus.ready !== 1'b1) @(posedge clock);
      case (index)
         REG_OP_MODE: cfg_op     = data[1:0];
         REG_A_ROWS:  cfg_a_rows = data[DIM_W-1:0];
         REG_A_COLS:  cfg_a_cols = data[DIM_W-1:0];
         REG_B_ROWS:  cfg_b_rows = data[DIM_W-1:0];
         REG_B_COLS:  cfg_b_cols = data[DIM_W-1:0];
         REG_SCALE:   cfg_scale  = data;
         default: ;
      endcase
   endtask

   // every register in one back-to-back run of transfers, block idle
   task automatic program_regs(logic [1:0] op, logic [DIM_W-1:0] ar, logic [DIM_W-1:0] ac,
                               logic [DIM_W-1:0] br, logic [DIM_W-1:0] bc,
                               logic signed [ELEM_W-1:0] scale);
      wait_until_drained();
      write_reg(REG_OP_MODE, pad_field(32'(op), 2));
      write_reg(REG_A_ROWS,  pad_field(32'(ar), DIM_W));
      write_reg(REG_A_COLS,  pad_field(32'(ac), DIM_W));
      write_reg(REG_B_ROWS,  pad_field(32'(br), DIM_W));
      write_reg(REG_B_COLS,  pad_field(32'(bc), DIM_W));
      write_reg(REG_SCALE,   scale);
      csr_bus.valid <= 1'b0;
   endtask

   // load every element the next start will read that has never been written
   task automatic load_missing_operands();
      int rows, cols, inner;
      if (run_shape(rows, cols) != STAT_OK)
         return;
      inner = (cfg_op == OP_MUL) ? int'(cfg_a_cols) : 1;
      for (int r = 0; r < rows; r++) begin
         for (int c = 0; c < cols; c++) begin
            for (int i = 0; i < inner; i++) begin
               if (cfg_op == OP_MUL) begin
                  if (!mat_a_loaded[r * 8 + i])
                     send_item(KIND_LOAD_A, rand_elem(), IDX_W'(r), IDX_W'(i));
                  if (!mat_b_loaded[i * 8 + c])
                     send_item(KIND_LOAD_B, rand_elem(), IDX_W'(i), IDX_W'(c));
               end else begin
                  if (!mat_a_loaded[r * 8 + c])
                     send_item(KIND_LOAD_A, rand_elem(), IDX_W'(r), IDX_W'(c));
                  if (cfg_op != OP_SCALE && !mat_b_loaded[r * 8 + c])
                     send_item(KIND_LOAD_B, rand_elem(), IDX_W'(r), IDX_W'(c));
               end
            end
         end
      end
   endtask

   // ---------------------------------------------------------------- tests

   // registers straight out of reset give an empty result; unused kind is dropped
   task automatic test_reset_state();
      send_item(KIND_UNUSED, $urandom(), IDX_W'($urandom()), IDX_W'($urandom()));
      send_start();
   endtask

   task automatic test_elementwise_extremes();
      program_regs(OP_ADD, 4'd2, 4'd2, 4'd2, 4'd2, SCALE_RESET);
      send_item(KIND_LOAD_A, 32'sh7FFF_FFFF, 3'd0, 3'd0);
      send_item(KIND_LOAD_A, 32'sh8000_0000, 3'd0, 3'd1);
      send_item(KIND_LOAD_A, 32'sd0,         3'd1, 3'd0);
      send_item(KIND_LOAD_A, -32'sd1,        3'd1, 3'd1);
      send_item(KIND_LOAD_B, 32'sd1,         3'd0, 3'd0);
      send_item(KIND_LOAD_B, -32'sd1,        3'd0, 3'd1);
      send_item(KIND_LOAD_B, 32'sh8000_0000, 3'd1, 3'd0);
      send_item(KIND_LOAD_B, 32'sh0001_0000, 3'd1, 3'd1);
      send_start();
      program_regs(OP_SUB, 4'd2, 4'd2, 4'd2, 4'd2, SCALE_RESET);
      send_start();
   endtask

   task automatic test_product_and_scale();
      program_regs(OP_MUL, 4'd2, 4'd2, 4'd2, 4'd2, SCALE_RESET);
      send_start();
      program_regs(OP_SCALE, 4'd2, 4'd2, 4'd0, 4'd0, 32'sh8000_0000);
      send_start();
      program_regs(OP_SCALE, 4'd2, 4'd2, 4'd0, 4'd0, 32'sh7FFF_FFFF);
      send_start();
   endtask

   task automatic test_shape_errors();
      // element-wise shapes differ
      program_regs(OP_ADD, 4'd2, 4'd2, 4'd2, 4'd3, SCALE_RESET);
      send_start();
      // inner dimensions differ
      program_regs(OP_MUL, 4'd2, 4'd3, 4'd2, 4'd2, SCALE_RESET);
      send_start();
      // too many rows
      program_regs(OP_SUB, 4'd9, 4'd2, 4'd9, 4'd2, SCALE_RESET);
      send_start();
      // a zero side wins over an oversized one: both operands become 0 x 0
      program_regs(OP_ADD, 4'd12, 4'd0, 4'd0, 4'd5, SCALE_RESET);
      send_start();
      program_regs(OP_MUL, 4'd2, 4'd0, 4'd0, 4'd3, SCALE_RESET);
      send_start();
      // scale ignores B, even an oversized one
      program_regs(OP_SCALE, 4'd2, 4'd2, 4'd15, 4'd15, 32'sh0002_8000);
      send_start();
   endtask

   task automatic test_random_jobs();
      int op, ar, ac, br, bc, runs, loads;
      logic signed [ELEM_W-1:0] scale;
      while (items_sent < ITEM_TARGET) begin
         op = $urandom_range(0, 3);
         ar = $urandom_range(1, 4);
         ac = $urandom_range(1, 4);
         bc = $urandom_range(1, 4);
         case ($urandom_range(0, 19))
            0: begin
               ar = 8;
               ac = 8;
               bc = 8;
            end
            1, 2: begin
               ar = $urandom_range(0, 15);
               ac = $urandom_range(0, 15);
            end
            default: ;
         endcase
         case (op)
            OP_MUL:   br = ac;
            OP_SCALE: begin
               br = $urandom_range(0, 15);
               bc = $urandom_range(0, 15);
            end
            default: begin
               br = ar;
               bc = ac;
            end
         endcase
         if ($urandom_range(0, 9) == 0)
            br = $urandom_range(0, 15);
         case ($urandom_range(0, 9))
            0: scale = 32'sh7FFF_FFFF;
            1: scale = 32'sh8000_0000;
            2, 3, 4: scale = int'($urandom_range(0, 1 << 19)) - (1 << 18);
            default: scale = $urandom();
         endcase
         program_regs(2'(op), DIM_W'(ar), DIM_W'(ac), DIM_W'(br), DIM_W'(bc), scale);
         runs = $urandom_range(1, 2);
         repeat (runs) begin
            loads = $urandom_range(0, 6);
            repeat (loads)
               send_item($urandom_range(0, 1) ? KIND_LOAD_B : KIND_LOAD_A, rand_elem(),
                         IDX_W'($urandom()), IDX_W'($urandom()));
            if ($urandom_range(0, 9) == 0)
               send_item(KIND_UNUSED, $urandom(), IDX_W'($urandom()), IDX_W'($urandom()));
            load_missing_operands();
            send_start();
         end
      end
   endtask

   // ---------------------------------------------------------------- result checker

   always @(posedge clock) begin
      elem_result_type want;
      if (reset === 1'b0 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (pending_elems.size() == 0) begin
            $error("unexpected result transfer: row %0d col %0d status %0d",
                   rsp_bus.out_row, rsp_bus.out_col, rsp_bus.out_status);
            error_count++;
         end else begin
            want = pending_elems.pop_front();
            elems_checked++;
            if (want.status == STAT_SAT)
               sat_seen++;
            if (want.status == STAT_DIM || want.status == STAT_EMPTY)
               flagged_seen++;
            if (rsp_bus.out_value !== want.value) begin
               $error("out_value mismatch: expected %0d, got %0d", want.value,
                      rsp_bus.out_value);
               error_count++;
            end
            if (rsp_bus.out_row !== want.row) begin
               $error("out_row mismatch: expected %0d, got %0d", want.row, rsp_bus.out_row);
               error_count++;
            end
            if (rsp_bus.out_col !== want.col) begin
               $error("out_col mismatch: expected %0d, got %0d", want.col, rsp_bus.out_col);
               error_count++;
            end
            if (rsp_bus.out_last !== want.last) begin
               $error("out_last mismatch: expected %0d, got %0d", want.last,
                      rsp_bus.out_last);
               error_count++;
            end
            if (rsp_bus.out_status !== want.status) begin
               $error("out_status mismatch: expected %0d, got %0d", want.status,
                      rsp_bus.out_status);
               error_count++;
            end
         end
      end
   end

   // receiver back-pressure: streaming, coin-toss and occasional long stalls
   initial begin
      rx_mode_type rx_mode;
      int          mode_left, stall_left;
      rsp_bus.ready <= 1'b0;
      rx_mode    = RX_STREAM;
      mode_left  = 0;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (mode_left == 0) begin
            rx_mode   = rx_mode_type'($urandom_range(0, 2));
            mode_left = $urandom_range(20, 200);
         end
         mode_left--;
         case (rx_mode)
            RX_STREAM: rsp_bus.ready <= 1'b1;
            RX_RANDOM: rsp_bus.ready <= 1'($urandom_range(0, 1));
            default: begin
               if (stall_left > 0) begin
                  stall_left--;
                  rsp_bus.ready <= 1'b0;
               end else begin
                  rsp_bus.ready <= 1'b1;
                  if ($urandom_range(0, 7) == 0)
                     stall_left = $urandom_range(1, 16);
               end
            end
         endcase
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.kind       <= KIND_LOAD_A;
      req_bus.elem_value <= '0;
      req_bus.elem_row   <= '0;
      req_bus.elem_col   <= '0;
      csr_bus.valid      <= 1'b0;
      csr_bus.index      <= REG_OP_MODE;
      csr_bus.data       <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_elementwise_extremes();
      test_product_and_scale();
      test_shape_errors();
      test_random_jobs();

      wait_until_drained();
      $display("Sent %0d load/start items (%0d starts) across add, subtract, product and scale.",
               items_sent, starts_sent);
      $display("Checked %0d result transfers: %0d saturated, %0d shape error or empty.",
               elems_checked, sat_seen, flagged_seen);
      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // watchdog, well beyond the slowest legal run
   initial begin
      #30_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
